// File: hdl/brh_pkg.sv
// ----------------------------------------------------------------------------
// brh_pkg
// Shared widths, types and constants of the bistatic range Hessian block.
// ----------------------------------------------------------------------------
package brh_pkg;

    // Position format is Q(32-FRAC_BITS).FRAC_BITS, results are Q2.30.
    localparam int FRAC_BITS = 16;

    localparam int POS_W   = 32;            // position and config width
    localparam int OUT_W   = 32;            // Hessian entry width
    localparam int NDIM    = 3;
    localparam int NSITE   = 2;             // site 0 receiver, site 1 transmitter
    localparam int NENT    = 6;             // xx, xy, xz, yy, yz, zz

    localparam int D_W     = POS_W + 1;     // exact difference
    localparam int ABS_W   = POS_W;         // magnitude of the difference
    localparam int SHAMT_W = $clog2(ABS_W);
    localparam int BL_W    = SHAMT_W + 1;   // bit length 0 .. ABS_W
    localparam int K_W     = BL_W + 1;      // signed normalising shift
    localparam int A_W     = ABS_W - 1;     // normalised magnitude
    localparam int P_W     = 2 * A_W;       // product of two magnitudes
    localparam int S_W     = 64;            // sum of squares
    localparam int ROOT_W  = S_W / 2;
    localparam int Q_W     = 33;            // num * 2^32 / S, up to 2^32
    localparam int V_SHIFT = 30;            // scaling before the root divide
    localparam int V_W     = Q_W;
    localparam int ACC_W   = 64;
    localparam int SH_W    = 8;

    localparam int NORM_STAGES = 5;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int FRAC_STAGES = Q_W;
    localparam int QUOT_STAGES = V_W;
    localparam int QLO         = QUOT_STAGES - V_SHIFT;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = POS_W;

    localparam int ENT_ROW [NENT] = '{0, 0, 0, 1, 1, 2};
    localparam int ENT_COL [NENT] = '{0, 1, 2, 1, 2, 2};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_ON_RX = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TX_X = 3'd0,
        REG_TX_Y = 3'd1,
        REG_TX_Z = 3'd2,
        REG_RX_X = 3'd3,
        REG_RX_Y = 3'd4,
        REG_RX_Z = 3'd5,
        REG_DIMS = 3'd6,
        REG_HALF = 3'd7
    } t_cfg_reg;

    // Per-site information that travels beside the divider pipelines.
    typedef struct packed {
        logic                  zero;   // target sits on this site
        logic signed [K_W-1:0] k;      // normalising shift
        logic [NENT-1:0]       nr;     // entry term is negated
    } t_site_side;

endpackage

// File: hdl/brh_norm.sv
// ----------------------------------------------------------------------------
// brh_norm
// Five-stage front end: differences, normalisation, products and numerators.
// ----------------------------------------------------------------------------
module brh_norm (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [brh_pkg::NDIM-1:0][brh_pkg::POS_W-1:0]  i_target,
    input  logic [brh_pkg::NDIM-1:0][brh_pkg::POS_W-1:0]  i_site,
    input  logic [brh_pkg::NDIM-1:0]                      i_dim_en,
    output logic [brh_pkg::S_W-1:0]                       o_s,
    output logic [brh_pkg::NENT-1:0][brh_pkg::S_W-1:0]    o_num,
    output brh_pkg::t_site_side                           o_side
);
    import brh_pkg::*;

    // Stage 1: exact differences and their magnitudes.
    logic signed [D_W-1:0]   n1_d   [NDIM];
    logic [ABS_W-1:0]        n1_a   [NDIM];
    logic [ABS_W-1:0]        r1_a   [NDIM];
    logic [NDIM-1:0]         r1_neg;
    logic                    r1_zero;

    always_comb begin
        for (int i = 0; i < NDIM; i++) begin
            n1_d[i] = i_dim_en[i] ? ($signed({i_target[i][POS_W-1], i_target[i]})
                                   - $signed({i_site[i][POS_W-1], i_site[i]}))
                                  : '0;
            n1_a[i] = n1_d[i][D_W-1] ? ABS_W'(-n1_d[i]) : ABS_W'(n1_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NDIM; i++) begin
                r1_a[i]   <= n1_a[i];
                r1_neg[i] <= n1_d[i][D_W-1];
            end
            r1_zero <= (n1_a[0] == '0) && (n1_a[1] == '0) && (n1_a[2] == '0);
        end
    end

    // Stage 2: bit length of the largest magnitude, taken from the OR.
    logic [ABS_W-1:0]      n2_or;
    logic [BL_W-1:0]       n2_bl;
    logic [ABS_W-1:0]      r2_a [NDIM];
    logic [NDIM-1:0]       r2_neg;
    logic                  r2_zero;
    logic signed [K_W-1:0] r2_k;

    always_comb begin
        n2_or = r1_a[0] | r1_a[1] | r1_a[2];
        n2_bl = '0;
        for (int i = 0; i < ABS_W; i++) begin
            if (n2_or[i]) n2_bl = BL_W'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a    <= r1_a;
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_k    <= K_W'(ABS_W - 1) - $signed({1'b0, n2_bl});
        end
    end

    // Stage 3: scale so that the largest magnitude fills A_W bits.
    logic [A_W-1:0]        r3_a [NDIM];
    logic [NENT-1:0]       r3_nr;
    logic                  r3_zero;
    logic signed [K_W-1:0] r3_k;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NDIM; i++) begin
                r3_a[i] <= r2_k[K_W-1] ? A_W'(r2_a[i] >> 1)
                                       : A_W'(r2_a[i] << r2_k[SHAMT_W-1:0]);
            end
            for (int e = 0; e < NENT; e++) begin
                r3_nr[e] <= (ENT_ROW[e] != ENT_COL[e])
                            && (r2_neg[ENT_ROW[e]] == r2_neg[ENT_COL[e]]);
            end
            r3_zero <= r2_zero;
            r3_k    <= r2_k;
        end
    end

    // Stage 4: the six products.
    logic [P_W-1:0]        r4_p [NENT];
    logic [NENT-1:0]       r4_nr;
    logic                  r4_zero;
    logic signed [K_W-1:0] r4_k;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < NENT; e++) begin
                r4_p[e] <= P_W'(r3_a[ENT_ROW[e]]) * P_W'(r3_a[ENT_COL[e]]);
            end
            r4_nr   <= r3_nr;
            r4_zero <= r3_zero;
            r4_k    <= r3_k;
        end
    end

    // Stage 5: sum of squares and numerators.
    logic [S_W-1:0] n5_s;

    always_comb begin
        n5_s = '0;
        for (int e = 0; e < NENT; e++) begin
            if (ENT_ROW[e] == ENT_COL[e]) n5_s = n5_s + S_W'(r4_p[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s <= n5_s;
            for (int e = 0; e < NENT; e++) begin
                o_num[e] <= (ENT_ROW[e] == ENT_COL[e]) ? (n5_s - S_W'(r4_p[e]))
                                                       : S_W'(r4_p[e]);
            end
            o_side.zero <= r4_zero;
            o_side.k    <= r4_k;
            o_side.nr   <= r4_nr;
        end
    end

endmodule

// File: hdl/brh_sqrt.sv
// ----------------------------------------------------------------------------
// brh_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module brh_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [brh_pkg::S_W-1:0]       i_s,
    output logic [brh_pkg::ROOT_W-1:0]    o_root
);
    import brh_pkg::*;

    logic [S_W-1:0] r_v   [SQRT_STAGES];
    logic [S_W-1:0] r_res [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam logic [S_W-1:0] BIT = S_W'(1) << (S_W - 2 - 2 * j);
        logic [S_W-1:0] v_in;
        logic [S_W-1:0] res_in;
        logic [S_W-1:0] trial;

        if (j == 0) begin : g_first
            assign v_in   = i_s;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign res_in = r_res[j-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[j]   <= v_in - trial;
                    r_res[j] <= (res_in >> 1) + BIT;
                end else begin
                    r_v[j]   <= v_in;
                    r_res[j] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// File: hdl/brh_frac.sv
// ----------------------------------------------------------------------------
// brh_frac
// Pipelined fraction divider: floor(num * 2^32 / S) for all six entries.
// ----------------------------------------------------------------------------
module brh_frac (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic [brh_pkg::S_W-1:0]                     i_s,
    input  logic [brh_pkg::NENT-1:0][brh_pkg::S_W-1:0]  i_num,
    output logic [brh_pkg::NENT-1:0][brh_pkg::Q_W-1:0]  o_q
);
    import brh_pkg::*;

    logic [S_W-1:0] r_s   [FRAC_STAGES];
    logic [S_W-1:0] r_rem [FRAC_STAGES][NENT];
    logic [Q_W-1:0] r_q   [FRAC_STAGES][NENT];

    for (genvar j = 0; j < FRAC_STAGES; j++) begin : g_stage
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) r_s[0] <= i_s;
            end
            for (genvar e = 0; e < NENT; e++) begin : g_ent
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (i_num[e] >= i_s) begin
                            r_rem[0][e] <= i_num[e] - i_s;
                            r_q[0][e]   <= Q_W'(1);
                        end else begin
                            r_rem[0][e] <= i_num[e];
                            r_q[0][e]   <= '0;
                        end
                    end
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) r_s[j] <= r_s[j-1];
            end
            for (genvar e = 0; e < NENT; e++) begin : g_ent
                logic [S_W-1:0] shl;
                logic           take;

                // The bit shifted out of the top always means the divisor fits.
                assign shl  = {r_rem[j-1][e][S_W-2:0], 1'b0};
                assign take = r_rem[j-1][e][S_W-1] || (shl >= r_s[j-1]);

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j][e] <= take ? (shl - r_s[j-1]) : shl;
                        r_q[j][e]   <= {r_q[j-1][e][Q_W-2:0], take};
                    end
                end
            end
        end
    end

    for (genvar e = 0; e < NENT; e++) begin : g_out
        assign o_q[e] = r_q[FRAC_STAGES-1][e];
    end

endmodule

// File: hdl/brh_quot.sv
// ----------------------------------------------------------------------------
// brh_quot
// Pipelined restoring divider: floor(q * 2^30 / root) for all six entries.
// ----------------------------------------------------------------------------
module brh_quot (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [brh_pkg::NENT-1:0][brh_pkg::Q_W-1:0]   i_q,
    input  logic [brh_pkg::ROOT_W-1:0]                   i_root,
    output logic [brh_pkg::NENT-1:0][brh_pkg::V_W-1:0]   o_v
);
    import brh_pkg::*;

    logic [ROOT_W-1:0] r_root [QUOT_STAGES];
    logic [ROOT_W-1:0] r_rem  [QUOT_STAGES][NENT];
    logic [V_W-1:0]    r_quo  [QUOT_STAGES][NENT];
    logic [QLO-1:0]    r_qlo  [QUOT_STAGES][NENT];

    for (genvar j = 0; j < QUOT_STAGES; j++) begin : g_stage
        // Dividend bit brought down in this stage.
        localparam int B = QUOT_STAGES - 1 - j;
        logic [ROOT_W-1:0] root_in;

        if (j == 0) begin : g_first
            assign root_in = i_root;
        end else begin : g_next
            assign root_in = r_root[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_root[j] <= root_in;
        end

        for (genvar e = 0; e < NENT; e++) begin : g_ent
            logic [ROOT_W-1:0] rem_in;
            logic [V_W-1:0]    quo_in;
            logic [QLO-1:0]    qlo_in;
            logic              nbit;
            logic [ROOT_W:0]   cand;
            logic              take;

            if (j == 0) begin : g_first
                // The dividend's top part is below the root, so it seeds the remainder.
                assign rem_in = ROOT_W'(i_q[e][Q_W-1:QLO]);
                assign quo_in = '0;
                assign qlo_in = i_q[e][QLO-1:0];
            end else begin : g_next
                assign rem_in = r_rem[j-1][e];
                assign quo_in = r_quo[j-1][e];
                assign qlo_in = r_qlo[j-1][e];
            end

            if (B >= V_SHIFT) begin : g_data
                assign nbit = qlo_in[B-V_SHIFT];
            end else begin : g_pad
                assign nbit = 1'b0;
            end

            assign cand = {rem_in, nbit};
            assign take = cand >= {1'b0, root_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j][e] <= take ? ROOT_W'(cand - {1'b0, root_in})
                                        : cand[ROOT_W-1:0];
                    r_quo[j][e] <= {quo_in[V_W-2:0], take};
                    r_qlo[j][e] <= qlo_in;
                end
            end
        end
    end

    for (genvar e = 0; e < NENT; e++) begin : g_out
        assign o_v[e] = r_quo[QUOT_STAGES-1][e];
    end

endmodule

// File: hdl/bistatic_range_hessian.sv
// ----------------------------------------------------------------------------
// bistatic_range_hessian
// Hessian of bistatic range with respect to the target position.
// ----------------------------------------------------------------------------
// One item in is a target position (Q16.16 x, y, z); one item out is the six
// unique Hessian entries (Q2.30, saturated) and a status code. Both channels
// use valid and stall: an item moves on a rising edge with valid high and
// stall low. The transmitter and receiver positions, the dimension count and
// the half-range mode are written through the plain configuration port; the
// user must write them only while no item is in flight; the block does not
// enforce it. From input acceptance to output valid an item passes five
// front-end stages, the 33-stage fraction divider (the square root runs
// beside it), the 33-stage root divider and three stages of shifting,
// summing, halving and saturation. An item may enter every cycle while the
// output is not stalled, so the sustained rate is one item per cycle.
// The whole pipeline advances on one enable. When the receiver stalls while
// an item waits in the output register, every stage holds and the input
// stall rises in the same cycle; nothing is lost or repeated. Reset clears
// all valid bits and returns the configuration to its reset values.
// ----------------------------------------------------------------------------
module bistatic_range_hessian (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [brh_pkg::POS_W-1:0]        i_target_x,
    input  logic [brh_pkg::POS_W-1:0]        i_target_y,
    input  logic [brh_pkg::POS_W-1:0]        i_target_z,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [brh_pkg::OUT_W-1:0]        o_h_xx,
    output logic [brh_pkg::OUT_W-1:0]        o_h_xy,
    output logic [brh_pkg::OUT_W-1:0]        o_h_xz,
    output logic [brh_pkg::OUT_W-1:0]        o_h_yy,
    output logic [brh_pkg::OUT_W-1:0]        o_h_yz,
    output logic [brh_pkg::OUT_W-1:0]        o_h_zz,
    output logic [1:0]                       o_status,
    // configuration port
    input  logic                             i_cfg_we,
    input  logic [brh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [brh_pkg::CFG_W-1:0]        i_cfg_data
);
    import brh_pkg::*;

    localparam int SIDE_DEPTH = FRAC_STAGES + QUOT_STAGES;
    localparam int VLD_DEPTH  = NORM_STAGES + FRAC_STAGES + QUOT_STAGES + 2;
    localparam logic signed [ACC_W-1:0] H_MAX =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] H_MIN =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers. Site 0 is the receiver, site 1 the
    // transmitter, so the receiver term is the one that decides status.
    // ------------------------------------------------------------------
    logic [NSITE-1:0][NDIM-1:0][POS_W-1:0] r_site;
    logic [1:0]                            r_num_dims;
    logic                                  r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site     <= '0;
            r_num_dims <= 2'd3;
            r_half     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_TX_X: r_site[1][0] <= i_cfg_data;
                REG_TX_Y: r_site[1][1] <= i_cfg_data;
                REG_TX_Z: r_site[1][2] <= i_cfg_data;
                REG_RX_X: r_site[0][0] <= i_cfg_data;
                REG_RX_Y: r_site[0][1] <= i_cfg_data;
                REG_RX_Z: r_site[0][2] <= i_cfg_data;
                REG_DIMS: r_num_dims   <= i_cfg_data[1:0];
                REG_HALF: r_half       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable and valid chain. The only place the pipeline can be
    // held is the output register, so one enable serves every stage.
    // ------------------------------------------------------------------
    logic                 en;
    logic [VLD_DEPTH-1:0] r_vld;
    logic                 r_out_valid;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[VLD_DEPTH-2:0], i_valid};
            r_out_valid <= r_vld[VLD_DEPTH-1];
        end
    end

    assign o_valid = r_out_valid;

    // Dimensions in use. A count of zero behaves as one dimension.
    logic [NDIM-1:0]              dim_en;
    logic [NDIM-1:0][POS_W-1:0]   target;

    always_comb begin
        case (r_num_dims)
            2'd2:    dim_en = 3'b011;
            2'd3:    dim_en = 3'b111;
            default: dim_en = 3'b001;
        endcase
    end

    assign target = {i_target_z, i_target_y, i_target_x};

    // ------------------------------------------------------------------
    // Per-site datapath: front end, then the square root in parallel with
    // the fraction divider, then the root divider. The root comes out one
    // stage earlier than the fraction and is registered again in r_root_d.
    // ------------------------------------------------------------------
    logic [S_W-1:0]                norm_s    [NSITE];
    logic [NENT-1:0][S_W-1:0]      norm_num  [NSITE];
    t_site_side [NSITE-1:0]        norm_side;
    logic [ROOT_W-1:0]             sqrt_root [NSITE];
    logic [ROOT_W-1:0]             r_root_d  [NSITE];
    logic [NENT-1:0][Q_W-1:0]      frac_q    [NSITE];
    logic [NENT-1:0][V_W-1:0]      quot_v    [NSITE];

    for (genvar s = 0; s < NSITE; s++) begin : g_site
        brh_norm u_norm (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_target (target),
            .i_site   (r_site[s]),
            .i_dim_en (dim_en),
            .o_s      (norm_s[s]),
            .o_num    (norm_num[s]),
            .o_side   (norm_side[s])
        );

        brh_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_s    (norm_s[s]),
            .o_root (sqrt_root[s])
        );

        always_ff @(posedge i_clk) begin
            if (en) r_root_d[s] <= sqrt_root[s];
        end

        brh_frac u_frac (
            .i_clk (i_clk),
            .i_en  (en),
            .i_s   (norm_s[s]),
            .i_num (norm_num[s]),
            .o_q   (frac_q[s])
        );

        brh_quot u_quot (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_q    (frac_q[s]),
            .i_root (r_root_d[s]),
            .o_v    (quot_v[s])
        );
    end

    // Side information waits in a plain delay line beside the dividers.
    t_site_side [NSITE-1:0] r_side [SIDE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= norm_side;
            for (int i = 1; i < SIDE_DEPTH; i++) r_side[i] <= r_side[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage F1: undo the normalisation (shift by FRAC_BITS + k - 32),
    // apply the sign and drop the term of a site the target sits on.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] f1_term   [NSITE][NENT];
    logic signed [ACC_W-1:0] r_f1_term [NSITE][NENT];
    logic                    r_f1_on_rx;

    for (genvar s = 0; s < NSITE; s++) begin : g_shift
        logic signed [SH_W-1:0] sh;
        logic [SH_W-1:0]        sh_neg;

        assign sh     = SH_W'(FRAC_BITS - 32) + SH_W'(r_side[SIDE_DEPTH-1][s].k);
        assign sh_neg = SH_W'(-sh);

        for (genvar e = 0; e < NENT; e++) begin : g_ent
            logic [ACC_W-1:0] vx;
            logic [ACC_W-1:0] mag;

            assign vx  = ACC_W'(quot_v[s][e]);
            assign mag = sh[SH_W-1] ? (vx >> sh_neg) : (vx << sh);

            always_comb begin
                if (r_side[SIDE_DEPTH-1][s].zero) begin
                    f1_term[s][e] = '0;
                end else if (r_side[SIDE_DEPTH-1][s].nr[e]) begin
                    f1_term[s][e] = -$signed(mag);
                end else begin
                    f1_term[s][e] = $signed(mag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_term  <= f1_term;
            r_f1_on_rx <= r_side[SIDE_DEPTH-1][0].zero;
        end
    end

    // Stage F2: sum of the receiver and transmitter terms.
    logic signed [ACC_W-1:0] r_f2_h [NENT];
    logic                    r_f2_on_rx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int e = 0; e < NENT; e++) begin
                r_f2_h[e] <= r_f1_term[0][e] + r_f1_term[1][e];
            end
            r_f2_on_rx <= r_f1_on_rx;
        end
    end

    // ------------------------------------------------------------------
    // Stage F3: halving toward zero, saturation, masking of the entries
    // that the dimension count leaves out, and the status code.
    // ------------------------------------------------------------------
    logic                    multi_dim;
    logic [NENT-1:0]         ent_en;
    logic signed [ACC_W-1:0] f3_half [NENT];
    logic [OUT_W-1:0]        f3_h    [NENT];
    logic [NENT-1:0]         f3_sat;
    t_status                 f3_status;
    logic [OUT_W-1:0]        r_out_h [NENT];
    t_status                 r_out_status;

    assign multi_dim = (r_num_dims == 2'd2) || (r_num_dims == 2'd3);

    always_comb begin
        for (int e = 0; e < NENT; e++) begin
            ent_en[e] = multi_dim && !r_f2_on_rx
                        && (ENT_ROW[e] < int'(r_num_dims))
                        && (ENT_COL[e] < int'(r_num_dims));
            if (r_half) begin
                // Adding the sign bit before the arithmetic shift rounds
                // negative sums toward zero.
                f3_half[e] = (r_f2_h[e]
                              + $signed({{(ACC_W-1){1'b0}}, r_f2_h[e][ACC_W-1]})) >>> 1;
            end else begin
                f3_half[e] = r_f2_h[e];
            end
            f3_sat[e] = 1'b0;
            if (!ent_en[e]) begin
                f3_h[e] = '0;
            end else if (f3_half[e] > H_MAX) begin
                f3_h[e]   = H_MAX[OUT_W-1:0];
                f3_sat[e] = 1'b1;
            end else if (f3_half[e] < H_MIN) begin
                f3_h[e]   = H_MIN[OUT_W-1:0];
                f3_sat[e] = 1'b1;
            end else begin
                f3_h[e] = f3_half[e][OUT_W-1:0];
            end
        end
        if (multi_dim && r_f2_on_rx) begin
            f3_status = ST_ON_RX;
        end else if (f3_sat != '0) begin
            f3_status = ST_SAT;
        end else begin
            f3_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_h      <= f3_h;
            r_out_status <= f3_status;
        end
    end

    assign o_h_xx   = r_out_h[0];
    assign o_h_xy   = r_out_h[1];
    assign o_h_xz   = r_out_h[2];
    assign o_h_yy   = r_out_h[3];
    assign o_h_yz   = r_out_h[4];
    assign o_h_zz   = r_out_h[5];
    assign o_status = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A target on the receiver gives an all-zero item.
    a_on_rx_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ON_RX) |->
            (o_h_xx == '0 && o_h_xy == '0 && o_h_xz == '0 &&
             o_h_yy == '0 && o_h_yz == '0 && o_h_zz == '0))
        else $error("non-zero entries with target on receiver");

    // Saturation status means at least one entry sits at a rail.
    a_sat_clamped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |->
            (o_h_xx == H_MAX[OUT_W-1:0] || o_h_xx == H_MIN[OUT_W-1:0] ||
             o_h_xy == H_MAX[OUT_W-1:0] || o_h_xy == H_MIN[OUT_W-1:0] ||
             o_h_xz == H_MAX[OUT_W-1:0] || o_h_xz == H_MIN[OUT_W-1:0] ||
             o_h_yy == H_MAX[OUT_W-1:0] || o_h_yy == H_MIN[OUT_W-1:0] ||
             o_h_yz == H_MAX[OUT_W-1:0] || o_h_yz == H_MIN[OUT_W-1:0] ||
             o_h_zz == H_MAX[OUT_W-1:0] || o_h_zz == H_MIN[OUT_W-1:0]))
        else $error("saturation status without a clamped entry");

    // Below 3D the z entries are zero.
    a_z_masked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_num_dims != 2'd3) |->
            (o_h_xz == '0 && o_h_yz == '0 && o_h_zz == '0))
        else $error("z entries non-zero below three dimensions");

endmodule

// File: tb/tb_bistatic_range_hessian.sv
// ----------------------------------------------------------------------------
// tb_bistatic_range_hessian
// Self-checking testbench for the bistatic range Hessian block.
// ----------------------------------------------------------------------------
// Target positions are sent through the valid/stall input channel. Each
// accepted item is run through a bit-exact predictor that lives in this
// file. The predicted entries and status are queued, and every item leaving
// the block is compared field by field with the oldest prediction. Site
// positions, dimension count and half-range mode are changed between phases,
// and only while nothing is in flight. In most random phases the sender
// works in random bursts, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_bistatic_range_hessian;
    timeunit 1ns;
    timeprecision 1ps;

    import brh_pkg::*;

    localparam int PIPE_DEPTH = 74;      // pipeline latency of the block
    localparam int IDLE_LIMIT = 4000;    // cycles with no item moving on either side

    typedef struct packed {
        logic [NENT-1:0][OUT_W-1:0] ent;  // xx, xy, xz, yy, yz, zz
        logic [1:0]                 st;
    } t_hessian;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [POS_W-1:0]     i_target_x;
    logic [POS_W-1:0]     i_target_y;
    logic [POS_W-1:0]     i_target_z;
    logic                 o_valid;
    logic                 i_stall;
    logic [OUT_W-1:0]     o_h_xx;
    logic [OUT_W-1:0]     o_h_xy;
    logic [OUT_W-1:0]     o_h_xz;
    logic [OUT_W-1:0]     o_h_yy;
    logic [OUT_W-1:0]     o_h_yz;
    logic [OUT_W-1:0]     o_h_zz;
    logic [1:0]           o_status;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bistatic_range_hessian u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_h_xx     (o_h_xx),
        .o_h_xy     (o_h_xy),
        .o_h_xz     (o_h_xz),
        .o_h_yy     (o_h_yy),
        .o_h_yz     (o_h_yz),
        .o_h_zz     (o_h_zz),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the configuration, kept in step with every write.
    logic signed [POS_W-1:0] site_pos [NSITE][NDIM];   // site 0 receiver, 1 transmitter
    logic [1:0]              dim_count;
    logic                    halve;

    t_hessian hessian_due [$];
    int       items_sent;
    int       items_checked;
    int       sat_seen;
    int       on_rx_seen;
    int       errors;
    bit       gaps_on;
    int       burst_left;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor arithmetic.
    // ------------------------------------------------------------------------

    // floor(a * 2^32 / b) for a <= b; the carry out of the top bit stands in
    // for the 65th bit of the running remainder.
    function automatic logic [63:0] frac_div32(logic [63:0] a, logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] q;
        logic        carry;
        rem = a;
        q   = '0;
        if (rem >= b) begin
            rem = rem - b;
            q   = 64'd1;
        end
        for (int i = 0; i < 32; i++) begin
            carry = rem[63];
            rem   = rem << 1;
            q     = q << 1;
            if (carry || rem >= b) begin
                rem  = rem - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Adds the second-derivative term of the distance to one site. The
    // differences are normalised so that the largest lies in [2^30, 2^31).
    function automatic void add_site_term(input longint d [NDIM], input int n,
                                          inout longint acc [NENT]);
        logic [63:0] mag_a [NDIM];
        bit          neg   [NDIM];
        logic [63:0] peak;
        logic [63:0] sumsq;
        logic [63:0] root;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] v;
        logic [63:0] mag;
        int          blen;
        int          k;
        int          sh;
        int          r;
        int          c;
        bit          negate;
        peak  = '0;
        sumsq = '0;
        blen  = 0;
        for (int i = 0; i < NDIM; i++) begin
            neg[i]   = 1'b0;
            mag_a[i] = '0;
        end
        for (int i = 0; i < n; i++) begin
            neg[i]   = d[i] < 0;
            mag_a[i] = neg[i] ? 64'(-d[i]) : 64'(d[i]);
            if (mag_a[i] > peak) peak = mag_a[i];
        end
        while (blen < 64 && (peak >> blen) != 0) blen++;
        k = 31 - blen;
        for (int i = 0; i < n; i++) begin
            mag_a[i] = (k >= 0) ? (mag_a[i] << k) : (mag_a[i] >> (-k));
            sumsq    = sumsq + mag_a[i] * mag_a[i];
        end
        root = floor_sqrt(sumsq);
        if (sumsq == 0 || root == 0) return;
        sh = FRAC_BITS + k - 32;
        for (int e = 0; e < NENT; e++) begin
            r = ENT_ROW[e];
            c = ENT_COL[e];
            if (r < n && c < n) begin
                if (r == c) begin
                    num    = sumsq - mag_a[r] * mag_a[r];
                    negate = 1'b0;
                end else begin
                    num    = mag_a[r] * mag_a[c];
                    negate = (neg[r] == neg[c]);
                end
                quo = frac_div32(num, sumsq);
                v   = (quo << 30) / root;
                mag = (sh >= 0) ? (v << sh) : (v >> (-sh));
                acc[e] = negate ? acc[e] - longint'(mag) : acc[e] + longint'(mag);
            end
        end
    endfunction

    function automatic t_hessian predict_hessian(logic [POS_W-1:0] tx, logic [POS_W-1:0] ty,
                                                 logic [POS_W-1:0] tz);
        longint   tgt   [NDIM];
        longint   d_rx  [NDIM];
        longint   d_tx  [NDIM];
        longint   acc   [NENT];
        bit       rx_hit;
        bit       tx_hit;
        int       n;
        t_hessian res;
        tgt[0] = longint'(signed'(tx));
        tgt[1] = longint'(signed'(ty));
        tgt[2] = longint'(signed'(tz));
        for (int i = 0; i < NDIM; i++) begin
            d_rx[i] = tgt[i] - longint'(site_pos[0][i]);
            d_tx[i] = tgt[i] - longint'(site_pos[1][i]);
        end
        for (int e = 0; e < NENT; e++) acc[e] = 0;
        res.st = ST_OK;
        n      = dim_count;
        if (n >= 2) begin
            rx_hit = 1'b1;
            tx_hit = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (d_rx[i] != 0) rx_hit = 1'b0;
                if (d_tx[i] != 0) tx_hit = 1'b0;
            end
            if (rx_hit) begin
                res.st = ST_ON_RX;
            end else begin
                add_site_term(d_rx, n, acc);
                if (!tx_hit) add_site_term(d_tx, n, acc);
                for (int e = 0; e < NENT; e++) begin
                    // Halving truncates toward zero, then each sum is clamped.
                    if (halve) acc[e] = acc[e] / 2;
                    if (acc[e] > 64'sd2147483647) begin
                        acc[e] = 64'sd2147483647;
                        res.st = ST_SAT;
                    end
                    if (acc[e] < -64'sd2147483648) begin
                        acc[e] = -64'sd2147483648;
                        res.st = ST_SAT;
                    end
                end
            end
        end
        for (int e = 0; e < NENT; e++) res.ent[e] = acc[e][OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: stall pattern and result checker.
    // ------------------------------------------------------------------------
    int stall_mode;
    int stall_left;
    int stall_phase;

    // The stall pattern switches at random between no stalling, random stalls
    // and regular stretches of stalling.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= (stall_phase + 1) % 13;
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                i_stall <= (stall_phase < 5);
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_hessian due;
        t_hessian got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.ent = {o_h_zz, o_h_yz, o_h_yy, o_h_xz, o_h_xy, o_h_xx};
            got.st  = o_status;
            if (hessian_due.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d", $time, got.st);
                errors++;
            end else begin
                due = hessian_due.pop_front();
                items_checked++;
                if (due.st == ST_SAT) sat_seen++;
                if (due.st == ST_ON_RX) on_rx_seen++;
                for (int e = 0; e < NENT; e++) begin
                    if (got.ent[e] !== due.ent[e]) begin
                        $display("%0t: entry %0d (row %0d col %0d) expected %h actual %h",
                                 $time, e, ENT_ROW[e], ENT_COL[e], due.ent[e], got.ent[e]);
                        errors++;
                    end
                end
                if (got.st !== due.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, due.st, got.st);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if nothing moves on either channel for too long.
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("bistatic_range_hessian verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Sends one target position. Valid stays high after acceptance so that
    // back-to-back items never lower and raise it within one step; a gap
    // between bursts lowers it explicitly.
    task automatic send_target(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
        i_valid    <= 1'b1;
        i_target_x <= x;
        i_target_y <= y;
        i_target_z <= z;
        do @(posedge i_clk); while (o_stall);
        hessian_due.push_back(predict_hessian(x, y, z));
        items_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Lowers valid and waits until every predicted result has been checked.
    // Every item gives exactly one result, so an empty queue means idle.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hessian_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TX_X: site_pos[1][0] = data;
            REG_TX_Y: site_pos[1][1] = data;
            REG_TX_Z: site_pos[1][2] = data;
            REG_RX_X: site_pos[0][0] = data;
            REG_RX_Y: site_pos[0][1] = data;
            REG_RX_Z: site_pos[0][2] = data;
            REG_DIMS: dim_count      = data[1:0];
            REG_HALF: halve          = data[0];
            default: ;
        endcase
    endtask

    task automatic set_sites(logic [POS_W-1:0] rx, logic [POS_W-1:0] ry, logic [POS_W-1:0] rz,
                             logic [POS_W-1:0] tx, logic [POS_W-1:0] ty, logic [POS_W-1:0] tz);
        write_reg(REG_RX_X, rx);
        write_reg(REG_RX_Y, ry);
        write_reg(REG_RX_Z, rz);
        write_reg(REG_TX_X, tx);
        write_reg(REG_TX_Y, ty);
        write_reg(REG_TX_Z, tz);
    endtask

    // A random coordinate: full range now and then, otherwise a signed offset
    // of random size from a given centre, so that both near and far targets
    // and the saturating region all appear.
    function automatic logic [POS_W-1:0] near_coord(logic [POS_W-1:0] centre);
        logic [POS_W-1:0] off;
        if ($urandom_range(0, 7) == 0) return $urandom;
        off = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) off = -off;
        if ($urandom_range(0, 9) == 0) off = '0;
        return centre + off;
    endfunction

    function automatic logic [POS_W-1:0] rand_site();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return $urandom;
            default: return $urandom >> $urandom_range(4, 24);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset configuration: both sites at the origin, three dimensions.
    task automatic test_reset_config();
        send_target('0, '0, '0);                              // on the receiver
        send_target(32'h0001_0000, '0, '0);
        send_target(32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000);
        drain_results();
    endtask

    // Directed corners: extremes, both sites hit, every dimension count and
    // saturation on a target one step from a site.
    task automatic test_directed_corners();
        gaps_on = 1'b0;
        set_sites(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
                  32'hFFE0_0000, 32'h0020_0000, 32'h8000_0000);
        write_reg(REG_DIMS, CFG_W'(3));
        write_reg(REG_HALF, CFG_W'(0));
        send_target(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000);   // on the receiver
        send_target(32'hFFE0_0000, 32'h0020_0000, 32'h8000_0000);   // on the transmitter
        send_target(32'h0010_0001, 32'hFFF0_0000, 32'h0000_8000);   // one step off: saturates
        send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_target(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_target(32'h0011_0000, 32'hFFF1_0000, 32'h0001_8000);
        drain_results();
        write_reg(REG_HALF, CFG_W'(1));
        send_target(32'h0010_0001, 32'hFFF0_0000, 32'h0000_8000);
        send_target(32'h0011_0000, 32'hFFF1_0000, 32'h0001_8000);
        send_target(32'h0010_0000, 32'hFFEF_FFFF, 32'h0000_8000);
        drain_results();
        write_reg(REG_DIMS, CFG_W'(2));
        // In 2D a differing z must not matter for the site hits.
        send_target(32'h0010_0000, 32'hFFF0_0000, 32'h1234_5678);
        send_target(32'hFFE0_0000, 32'h0020_0000, 32'h0000_0000);
        send_target(32'h0012_0000, 32'hFFF3_0000, 32'h7FFF_FFFF);
        send_target(32'h0010_0000, 32'hFFF0_0001, '0);
        drain_results();
        write_reg(REG_DIMS, CFG_W'(1));
        send_target(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000);
        send_target(32'h0055_0000, 32'h1234_0000, '0);
        drain_results();
        write_reg(REG_DIMS, CFG_W'(0));
        send_target(32'h0055_0000, 32'h1234_0000, '0);
        drain_results();
        write_reg(REG_HALF, CFG_W'(0));
    endtask

    // Random phases, each with its own sites, dimension count and mode.
    task automatic test_random_phases(int phases, int per_phase);
        int pick;
        for (int p = 0; p < phases; p++) begin
            drain_results();
            set_sites(rand_site(), rand_site(), rand_site(),
                      rand_site(), rand_site(), rand_site());
            write_reg(REG_DIMS, ($urandom_range(0, 9) == 0) ? CFG_W'(1)
                                                            : CFG_W'($urandom_range(2, 3)));
            write_reg(REG_HALF, CFG_W'($urandom_range(0, 1)));
            gaps_on = (p % 3 != 0);
            for (int i = 0; i < per_phase; i++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_target(site_pos[0][0], site_pos[0][1], site_pos[0][2]);
                end else if (pick == 1) begin
                    send_target(site_pos[1][0], site_pos[1][1], site_pos[1][2]);
                end else if (pick < 11) begin
                    send_target(near_coord(site_pos[0][0]), near_coord(site_pos[0][1]),
                                near_coord(site_pos[0][2]));
                end else begin
                    send_target(near_coord(site_pos[1][0]), near_coord(site_pos[1][1]),
                                near_coord(site_pos[1][2]));
                end
                // Now and then hold the sender back until the pipeline empties.
                if (i == per_phase / 2 && p % 4 == 1) drain_results();
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_target_x  = '0;
        i_target_y  = '0;
        i_target_z  = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_TX_X;
        i_cfg_data  = '0;
        stall_mode  = 0;
        stall_left  = 0;
        stall_phase = 0;
        idle_cycles = 0;
        for (int s = 0; s < NSITE; s++)
            for (int i = 0; i < NDIM; i++) site_pos[s][i] = '0;
        dim_count     = 2'd3;
        halve         = 1'b0;
        items_sent    = 0;
        items_checked = 0;
        sat_seen      = 0;
        on_rx_seen    = 0;
        errors        = 0;
        gaps_on       = 1'b0;
        burst_left    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_directed_corners();
        test_random_phases(11, 100);

        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("Checked %0d of %0d items over reset, directed and 11 random configurations;",
                 items_checked, items_sent);
        $display("%0d saturated results and %0d targets on the receiver among them.",
                 sat_seen, on_rx_seen);
        if (errors == 0 && hessian_due.size() == 0) begin
            $display("bistatic_range_hessian verification clean");
        end else begin
            $display("bistatic_range_hessian verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/brh_pkg.sv
hdl/brh_norm.sv
hdl/brh_sqrt.sv
hdl/brh_frac.sv
hdl/brh_quot.sv
hdl/bistatic_range_hessian.sv
tb/tb_bistatic_range_hessian.sv
